// File: design/mrrc_pkg.sv
// ----------------------------------------------------------------------------
// mrrc_pkg
// shared types and constants of the motor ramp and reversal controller
// ----------------------------------------------------------------------------
package mrrc_pkg;

	localparam int unsigned DutyW     = 8;
	localparam int unsigned StaleW    = 20;
	localparam int unsigned TimeW     = 32;
	localparam int unsigned AddrW     = 4;
	localparam int unsigned DataW     = 32;
	localparam int unsigned InTdataW  = 48;
	localparam int unsigned OutTdataW = 16;

	localparam logic [DutyW-1:0]  MaxStepRst  = 8'd8;
	localparam logic [StaleW-1:0] StaleRst    = 20'd20000;
	localparam logic [DutyW-1:0]  TopSpeedRst = 8'd250;

	// microseconds per unit of duty step
	localparam logic [TimeW-1:0] UsPerStep = 32'd1000;

	// floor(e / 1000) = (e * RecipMul) >> RecipShift, exact for e < 2^20
	localparam int unsigned      RecipW     = 21;
	localparam logic [RecipW-1:0] RecipMul  = 21'd1073742;
	localparam int unsigned      RecipShift = 30;
	localparam int unsigned      QuotW      = 11;
	localparam int unsigned      ProdW      = StaleW + RecipW;

	typedef enum logic [1:0] {
		REG_MAX_STEP    = 2'd0,
		REG_STALE_LIMIT = 2'd1,
		REG_TOP_SPEED   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [DutyW-1:0]  max_step;
		logic [StaleW-1:0] stale_limit;
		logic [DutyW-1:0]  top_speed;
	} cfg_t;

	typedef struct packed {
		logic [DutyW-1:0] duty;
		logic             dir;
		logic [TimeW-1:0] last_time;
		logic             pend;
	} ctl_st_t;

	typedef struct packed {
		logic             new_direction;
		logic [DutyW-1:0] target_speed;
		logic [TimeW-1:0] now_us;
	} req_t;

endpackage

// File: design/mrrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mrrc_cfg_regs
// apb register file: step limit, stale limit and speed ceiling
// ----------------------------------------------------------------------------
module mrrc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mrrc_pkg::AddrW-1:0]   paddr,
	input  logic [mrrc_pkg::DataW-1:0]   pwdata,
	output logic [mrrc_pkg::DataW-1:0]   prdata,
	output logic                         pready,
	output mrrc_pkg::cfg_t               cfg
);

	mrrc_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_step    <= mrrc_pkg::MaxStepRst;
			cfg_q.stale_limit <= mrrc_pkg::StaleRst;
			cfg_q.top_speed   <= mrrc_pkg::TopSpeedRst;
		end else if (wr_en) begin
			case (reg_sel)
				mrrc_pkg::REG_MAX_STEP:    cfg_q.max_step    <= pwdata[mrrc_pkg::DutyW-1:0];
				mrrc_pkg::REG_STALE_LIMIT: cfg_q.stale_limit <= pwdata[mrrc_pkg::StaleW-1:0];
				mrrc_pkg::REG_TOP_SPEED:   cfg_q.top_speed   <= pwdata[mrrc_pkg::DutyW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			mrrc_pkg::REG_MAX_STEP:
				prdata = {{(mrrc_pkg::DataW-mrrc_pkg::DutyW){1'b0}}, cfg_q.max_step};
			mrrc_pkg::REG_STALE_LIMIT:
				prdata = {{(mrrc_pkg::DataW-mrrc_pkg::StaleW){1'b0}}, cfg_q.stale_limit};
			mrrc_pkg::REG_TOP_SPEED:
				prdata = {{(mrrc_pkg::DataW-mrrc_pkg::DutyW){1'b0}}, cfg_q.top_speed};
			default:
				prdata = '0;
		endcase
	end

endmodule

// File: design/mrrc_step.sv
// ----------------------------------------------------------------------------
// mrrc_step
// one request against the current state: timer check, reversal, ramp
// ----------------------------------------------------------------------------
module mrrc_step (
	input  mrrc_pkg::cfg_t    cfg,
	input  mrrc_pkg::ctl_st_t st,
	input  mrrc_pkg::req_t    req,
	output mrrc_pkg::ctl_st_t st_nxt
);

	logic [mrrc_pkg::TimeW-1:0]  elapsed;
	logic                        e_zero;
	logic                        e_lt_min;
	logic                        e_lt_stale;
	logic                        e_gt_stale;
	logic                        rebase;
	logic                        step_en;
	logic [mrrc_pkg::ProdW-1:0]  prod;
	logic [mrrc_pkg::QuotW-1:0]  quot;
	logic [mrrc_pkg::DutyW-1:0]  step;
	logic [mrrc_pkg::DutyW-1:0]  duty_dn;
	logic [mrrc_pkg::DutyW:0]    duty_up;
	logic                        rev;
	logic                        settled;

	// elapsed time and its range
	assign elapsed    = req.now_us - st.last_time;
	assign e_zero     = (elapsed == '0);
	assign e_lt_min   = (elapsed < mrrc_pkg::UsPerStep);
	assign e_lt_stale = (elapsed <
		{{(mrrc_pkg::TimeW-mrrc_pkg::StaleW){1'b0}}, cfg.stale_limit});
	assign e_gt_stale = (elapsed >
		{{(mrrc_pkg::TimeW-mrrc_pkg::StaleW){1'b0}}, cfg.stale_limit});
	assign step_en    = !e_zero && !e_lt_min && e_lt_stale;
	assign rebase     = e_zero || (!e_lt_min && (e_lt_stale || e_gt_stale));

	// divide by 1000 through reciprocal, only used below the stale limit
	assign prod = {{mrrc_pkg::RecipW{1'b0}}, elapsed[mrrc_pkg::StaleW-1:0]} *
		{{mrrc_pkg::StaleW{1'b0}}, mrrc_pkg::RecipMul};
	assign quot = prod[mrrc_pkg::RecipShift+mrrc_pkg::QuotW-1:mrrc_pkg::RecipShift];

	always_comb begin
		if (!step_en)
			step = '0;
		else if (quot > {{(mrrc_pkg::QuotW-mrrc_pkg::DutyW){1'b0}}, cfg.max_step})
			step = cfg.max_step;
		else
			step = quot[mrrc_pkg::DutyW-1:0];
	end

	assign duty_dn = (step >= st.duty) ? '0 : st.duty - step;
	assign duty_up = {1'b0, st.duty} + {1'b0, step};

	assign rev     = (req.new_direction != st.dir) || st.pend;
	assign settled = (req.target_speed == st.duty) ||
		((req.target_speed == cfg.top_speed) && (st.duty >= cfg.top_speed));

	always_comb begin
		st_nxt = st;
		if (rev) begin
			st_nxt.duty = duty_dn;
			if (rebase)
				st_nxt.last_time = req.now_us;
			if (duty_dn == '0) begin
				st_nxt.pend = 1'b0;
				st_nxt.dir  = req.new_direction;
			end else begin
				st_nxt.pend = 1'b1;
			end
		end else if (!settled) begin
			if (rebase)
				st_nxt.last_time = req.now_us;
			if (req.target_speed < st.duty) begin
				if ((step > st.duty) || ((st.duty - step) < req.target_speed))
					st_nxt.duty = req.target_speed;
				else
					st_nxt.duty = st.duty - step;
			end else begin
				if (duty_up > {1'b0, req.target_speed})
					st_nxt.duty = req.target_speed;
				else
					st_nxt.duty = duty_up[mrrc_pkg::DutyW-1:0];
			end
		end
	end

endmodule

// File: design/motor_ramp_reversal_controller_core.sv
// ----------------------------------------------------------------------------
// motor_ramp_reversal_controller_core
// slew-rate limited h-bridge speed control with ramp-down before reversal
// ----------------------------------------------------------------------------
// requests come in on the s_ stream: direction, target duty and a free-running
// microsecond timestamp. each request gives exactly one word on the m_ stream:
// the duty, the active side and the reversing flag after the request.
// a request passes an input register and a result register; its word becomes
// valid when it advances from the first into the second, which waits while a
// finished result is held by m_tready low. the state update and the result are
// computed combinationally between the two registers.
// throughput is one request per cycle while m_tready drains the result; duty,
// direction, timer base and reversal flag are updated as each request advances.
// the input register still takes a word while a finished result waits on
// m_tready; with both registers full, s_tready drops until m_tready rises.
// reset clears the stream valids and sets duty 0, side forward, timer base 0,
// no reversal, and the registers to step 8, stale limit 20000, ceiling 250.
// the apb registers are written in the access phase (psel and penable high), pready is
// always high; write them only while no request is in flight.
// ----------------------------------------------------------------------------
module motor_ramp_reversal_controller_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mrrc_pkg::AddrW-1:0]       paddr,
	input  logic [mrrc_pkg::DataW-1:0]       pwdata,
	output logic [mrrc_pkg::DataW-1:0]       prdata,
	output logic                             pready,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// new_direction [0], target_speed [8:1], now_us [40:9], zero [47:41]
	input  logic [mrrc_pkg::InTdataW-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// pwm_duty [7:0], active_side [8], reversing [9], zero [15:10]
	output logic [mrrc_pkg::OutTdataW-1:0]   m_tdata
);

	mrrc_pkg::cfg_t    cfg;
	mrrc_pkg::ctl_st_t st_q;
	mrrc_pkg::ctl_st_t st_nxt;
	mrrc_pkg::req_t    req_s1;
	logic              valid_s1;
	logic              valid_s2;
	logic [mrrc_pkg::DutyW-1:0] duty_s2;
	logic              side_s2;
	logic              rev_s2;
	logic              advance;
	logic              in_take;

	mrrc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mrrc_step u_step (
		.cfg    (cfg),
		.st     (st_q),
		.req    (req_s1),
		.st_nxt (st_nxt)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_take  = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1.new_direction <= s_tdata[0];
			req_s1.target_speed  <= s_tdata[mrrc_pkg::DutyW:1];
			req_s1.now_us        <= s_tdata[mrrc_pkg::DutyW+mrrc_pkg::TimeW:mrrc_pkg::DutyW+1];
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.duty      <= '0;
			st_q.dir       <= 1'b1;
			st_q.last_time <= '0;
			st_q.pend      <= 1'b0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_s2 <= st_nxt.duty;
			side_s2 <= st_nxt.dir;
			rev_s2  <= st_nxt.pend;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(mrrc_pkg::OutTdataW-mrrc_pkg::DutyW-2){1'b0}},
		rev_s2, side_s2, duty_s2};

	// a pending reversal always has duty left to ramp down
	a_rev_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.pend |-> (st_q.duty != '0))
		else $error("reversal pending with zero duty");

	// the direction flips only once the duty is zero
	a_flip_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.dir != $past(st_q.dir)) |-> (st_q.duty == '0))
		else $error("direction changed with nonzero duty");

	// state moves only when a request is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("state changed without a request");

	// a processed request always leaves a result word
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("processed request without result");

endmodule

// File: test/tb_motor_ramp_reversal_controller_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motor_ramp_reversal_controller_core
// checks the duty ramp, the timer rules and the ramp-down before reversal
// ----------------------------------------------------------------------------
// a short table of hand-picked requests runs at the reset register values,
// then random requests run under several register settings, the extremes
// among them. timestamps are drawn around the rule boundaries: no elapsed
// time, waiting, stepping, exactly the stale limit, stale, and far jumps.
// every word is checked field by field against a bench model or a fixed table result.
// both streams idle and stall at random, and once the sink holds off long
// enough for the block to fill up and stall its input.
// ----------------------------------------------------------------------------
module tb_motor_ramp_reversal_controller_core;

	localparam int unsigned PhaseItems = 165;
	localparam int unsigned NumPhases  = 8;
	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned HoldCycles = 80;
	localparam int unsigned HoldAfter  = 400;

	typedef struct packed {
		logic                       rev;
		logic                       side;
		logic [mrrc_pkg::DutyW-1:0] duty;
	} drive_t;

	typedef struct packed {
		logic                       dir;
		logic [mrrc_pkg::DutyW-1:0] target;
		logic [mrrc_pkg::TimeW-1:0] now;
		logic                       known;
		drive_t                     want;
	} plan_row_t;

	// dir, target, now, known result, {reversing, side, duty}
	localparam plan_row_t Plan [0:23] = '{
		'{1'b1, 8'd0,   32'd0,        1'b1, '{1'b0, 1'b1, 8'd0}},
		'{1'b1, 8'd255, 32'd999,      1'b1, '{1'b0, 1'b1, 8'd0}},
		'{1'b1, 8'd255, 32'd1000,     1'b1, '{1'b0, 1'b1, 8'd1}},
		'{1'b1, 8'd255, 32'd1000,     1'b0, '0},
		'{1'b1, 8'd255, 32'd101000,   1'b0, '0},
		'{1'b1, 8'd255, 32'd121000,   1'b0, '0},
		'{1'b1, 8'd255, 32'd140999,   1'b0, '0},
		'{1'b1, 8'd9,   32'd150000,   1'b0, '0},
		'{1'b1, 8'd255, 32'hFFFFFFFF, 1'b0, '0},
		'{1'b1, 8'd255, 32'd3999,     1'b0, '0},
		'{1'b1, 8'd5,   32'd12000,    1'b0, '0},
		'{1'b1, 8'd0,   32'd30000,    1'b0, '0},
		'{1'b1, 8'd200, 32'd49999,    1'b0, '0},
		'{1'b1, 8'd200, 32'd69998,    1'b0, '0},
		'{1'b1, 8'd200, 32'd89997,    1'b0, '0},
		'{1'b0, 8'd100, 32'd94997,    1'b0, '0},
		'{1'b1, 8'd100, 32'd114996,   1'b0, '0},
		'{1'b1, 8'd100, 32'd134995,   1'b0, '0},
		'{1'b1, 8'd100, 32'd154994,   1'b0, '0},
		'{1'b0, 8'd0,   32'd155994,   1'b1, '{1'b0, 1'b0, 8'd0}},
		'{1'b0, 8'd255, 32'd175993,   1'b0, '0},
		'{1'b1, 8'd255, 32'd175993,   1'b0, '0},
		'{1'b1, 8'd250, 32'd195992,   1'b0, '0},
		'{1'b1, 8'd250, 32'd215991,   1'b0, '0}
	};

	// max_step, stale_limit, top_speed; the last phases are drawn at random
	localparam mrrc_pkg::cfg_t Settings [0:5] = '{
		'{8'd255, 20'hFFFFF,   8'd255},
		'{8'd1,   20'd1000,    8'd0},
		'{8'd0,   20'd999,     8'd128},
		'{8'd8,   20'd20000,   8'd250},
		'{8'd3,   20'd0,       8'd100},
		'{8'd200, 20'd1000000, 8'd255}
	};

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [mrrc_pkg::AddrW-1:0]     paddr;
	logic [mrrc_pkg::DataW-1:0]     pwdata;
	logic [mrrc_pkg::DataW-1:0]     prdata;
	logic                           pready;
	logic                           s_tvalid;
	logic                           s_tready;
	// new_direction [0], target_speed [8:1], now_us [40:9], zero [47:41]
	logic [mrrc_pkg::InTdataW-1:0]  s_tdata;
	logic                           m_tvalid;
	logic                           m_tready;
	// pwm_duty [7:0], active_side [8], reversing [9], zero [15:10]
	logic [mrrc_pkg::OutTdataW-1:0] m_tdata;

	mrrc_pkg::ctl_st_t          ctl;
	mrrc_pkg::cfg_t             regs;
	drive_t                     drive_q [$];
	logic                       want_dir;
	logic [mrrc_pkg::DutyW-1:0] want_target;
	int                         burst_left;
	bit                         hold_on;
	bit                         hold_done;
	int                         errors;
	int                         sent;
	int                         words_seen;
	int                         reversing_words;
	int                         cycles;

	motor_ramp_reversal_controller_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// duty step earned since last step; re-bases timer unless waiting or exactly stale
	function automatic logic [mrrc_pkg::DutyW-1:0] timer_step(
		input logic [mrrc_pkg::TimeW-1:0] now);
		logic [mrrc_pkg::TimeW-1:0] el;
		logic [mrrc_pkg::TimeW-1:0] q;
		el = now - ctl.last_time;
		if (el == '0) begin
			ctl.last_time = now;
			return '0;
		end
		if (el < mrrc_pkg::UsPerStep)
			return '0;
		if (el < regs.stale_limit) begin
			q = el / mrrc_pkg::UsPerStep;
			if (q > regs.max_step)
				q = regs.max_step;
			ctl.last_time = now;
			return q[mrrc_pkg::DutyW-1:0];
		end
		if (el > regs.stale_limit)
			ctl.last_time = now;
		return '0;
	endfunction

	function automatic drive_t advance_ramp(input mrrc_pkg::req_t rq);
		logic [mrrc_pkg::DutyW-1:0] d;
		drive_t                     w;
		if (rq.new_direction != ctl.dir || ctl.pend) begin
			ctl.pend = 1'b1;
			d = timer_step(rq.now_us);
			ctl.duty = (d >= ctl.duty) ? '0 : ctl.duty - d;
			if (ctl.duty == '0) begin
				ctl.pend = 1'b0;
				ctl.dir  = rq.new_direction;
			end
		end
		if (!(rq.target_speed == ctl.duty ||
				(rq.target_speed == regs.top_speed && ctl.duty >= regs.top_speed))) begin
			if (rq.target_speed < ctl.duty && !ctl.pend) begin
				d = timer_step(rq.now_us);
				if (d > ctl.duty || ctl.duty - d < rq.target_speed)
					ctl.duty = rq.target_speed;
				else
					ctl.duty = ctl.duty - d;
			end else if (!ctl.pend) begin
				d = timer_step(rq.now_us);
				if (int'(ctl.duty) + int'(d) > int'(rq.target_speed))
					ctl.duty = rq.target_speed;
				else
					ctl.duty = ctl.duty + d;
			end
		end
		w.duty = ctl.duty;
		w.side = ctl.dir;
		w.rev  = ctl.pend;
		return w;
	endfunction

	function automatic mrrc_pkg::req_t make_request();
		mrrc_pkg::req_t             rq;
		logic [mrrc_pkg::TimeW-1:0] el;
		logic [mrrc_pkg::TimeW-1:0] hi;
		int                         roll;
		if ($urandom_range(99) < 8)
			want_dir = ~want_dir;
		rq.new_direction = ($urandom_range(99) < 3) ? 1'($urandom) : want_dir;
		if ($urandom_range(99) < 10)
			want_target = 8'($urandom);
		roll = $urandom_range(99);
		if (roll < 35)
			rq.target_speed = want_target;
		else if (roll < 50)
			rq.target_speed = ctl.duty;
		else if (roll < 62)
			rq.target_speed = regs.top_speed;
		else if (roll < 67)
			rq.target_speed = '0;
		else if (roll < 72)
			rq.target_speed = '1;
		else
			rq.target_speed = 8'($urandom);
		hi = (regs.stale_limit > mrrc_pkg::UsPerStep) ? regs.stale_limit - 1 :
			mrrc_pkg::UsPerStep;
		roll = $urandom_range(99);
		if (roll < 8) begin
			el = '0;
		end else if (roll < 20) begin
			el = $urandom_range(1, 999);
		end else if (roll < 75) begin
			if ($urandom_range(1) == 1 && hi > 9999)
				hi = 9999;
			el = $urandom_range(mrrc_pkg::UsPerStep, hi);
		end else if (roll < 82) begin
			el = regs.stale_limit;
		end else if (roll < 90) begin
			el = regs.stale_limit + $urandom_range(1, 50000);
		end else begin
			el = $urandom();
		end
		rq.now_us = ctl.last_time + el;
		return rq;
	endfunction

	task automatic pace();
		int g;
		if (hold_on)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 24);
		g = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
		if (g > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic send_request(input mrrc_pkg::req_t rq, input logic known,
		input drive_t want);
		drive_t got;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, rq.now_us, rq.target_speed, rq.new_direction};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		got = advance_ramp(rq);
		drive_q.push_back(known ? want : got);
		sent++;
		pace();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input mrrc_pkg::reg_idx_t idx,
		input logic [mrrc_pkg::DataW-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			mrrc_pkg::REG_MAX_STEP:    regs.max_step    = val[mrrc_pkg::DutyW-1:0];
			mrrc_pkg::REG_STALE_LIMIT: regs.stale_limit = val[mrrc_pkg::StaleW-1:0];
			mrrc_pkg::REG_TOP_SPEED:   regs.top_speed   = val[mrrc_pkg::DutyW-1:0];
			default:                   ;
		endcase
		// read back
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== val) begin
			errors++;
			$display("%0t ns: register %s expected %0d got %0d", $time, idx.name(), val, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		mrrc_pkg::req_t rq;
		mrrc_pkg::cfg_t pick;
		int             i;
		int             ph;
		int             n;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		regs        = '{mrrc_pkg::MaxStepRst, mrrc_pkg::StaleRst, mrrc_pkg::TopSpeedRst};
		ctl         = '{8'd0, 1'b1, 32'd0, 1'b0};
		want_dir    = 1'b1;
		want_target = 8'd128;
		burst_left  = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < $size(Plan); i++) begin
			rq.new_direction = Plan[i].dir;
			rq.target_speed  = Plan[i].target;
			rq.now_us        = Plan[i].now;
			send_request(rq, Plan[i].known, Plan[i].want);
		end
		wait_idle();

		for (ph = 0; ph < NumPhases; ph++) begin
			if (ph < $size(Settings)) begin
				pick = Settings[ph];
			end else begin
				pick.max_step    = 8'($urandom);
				pick.stale_limit = (ph % 2 == 0) ? 20'($urandom) : 20'($urandom_range(1000, 60000));
				pick.top_speed   = 8'($urandom);
			end
			set_reg(mrrc_pkg::REG_MAX_STEP,
				{{(mrrc_pkg::DataW-mrrc_pkg::DutyW){1'b0}}, pick.max_step});
			set_reg(mrrc_pkg::REG_STALE_LIMIT,
				{{(mrrc_pkg::DataW-mrrc_pkg::StaleW){1'b0}}, pick.stale_limit});
			set_reg(mrrc_pkg::REG_TOP_SPEED,
				{{(mrrc_pkg::DataW-mrrc_pkg::DutyW){1'b0}}, pick.top_speed});
			for (n = 0; n < PhaseItems; n++) begin
				rq = make_request();
				send_request(rq, 1'b0, '0);
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		$display("%0d requests over %0d register settings plus the reset values",
			sent, NumPhases);
		$display("%0d words checked, %0d of them while reversing", words_seen, reversing_words);
		if (errors == 0)
			$display("tb_motor_ramp_reversal_controller_core: clean");
		else
			$display("tb_motor_ramp_reversal_controller_core: errors");
		$finish;
	end

	initial begin : sink
		int mode;
		int left;
		int k;
		mode      = 0;
		left      = 0;
		k         = 0;
		hold_on   = 1'b0;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && words_seen >= HoldAfter) begin
				hold_on = 1'b1;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_on   = 1'b0;
				hold_done = 1'b1;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(3);
					left = $urandom_range(8, 64);
				end
				left--;
				k++;
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(1));
					2:       m_tready <= (k % 4 == 0);
					default: m_tready <= ($urandom_range(9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_words
		drive_t want;
		drive_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			seen = m_tdata[9:0];
			words_seen++;
			if (seen.rev)
				reversing_words++;
			if (drive_q.size() == 0) begin
				errors++;
				$display("%0t ns: word %h with nothing expected", $time, m_tdata);
			end else begin
				want = drive_q.pop_front();
				if (seen.duty !== want.duty) begin
					errors++;
					$display("%0t ns: pwm_duty expected %0d got %0d", $time, want.duty, seen.duty);
				end
				if (seen.side !== want.side) begin
					errors++;
					$display("%0t ns: active_side expected %0b got %0b", $time, want.side,
						seen.side);
				end
				if (seen.rev !== want.rev) begin
					errors++;
					$display("%0t ns: reversing expected %0b got %0b", $time, want.rev, seen.rev);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("%0t ns: run did not finish within %0d cycles", $time, CycleLimit);
			$display("tb_motor_ramp_reversal_controller_core: errors");
			$finish;
		end
	end

endmodule

// File: motor_ramp_reversal_controller_core.f
design/mrrc_pkg.sv
design/mrrc_cfg_regs.sv
design/mrrc_step.sv
design/motor_ramp_reversal_controller_core.sv
test/tb_motor_ramp_reversal_controller_core.sv
